>>> sv/cbb_pkg.sv
`default_nettype none

package cbb_pkg;

    // Vertex lanes: x, y, z, width
    localparam int LANES  = 4;
    localparam int LANE_W = 32;
    // Weighted sums of four vertices per lane with weights up to 6 stay below 2^35
    localparam int ACC_W  = 36;

    // Basis modes
    localparam logic [1:0] MODE_LINEAR  = 2'd0;
    localparam logic [1:0] MODE_BEZIER  = 2'd1;
    localparam logic [1:0] MODE_BSPLINE = 2'd2;
    localparam logic [1:0] MODE_CATMULL = 2'd3;

    // Register map
    localparam logic REG_BASIS_MODE = 1'b0;

    // Point kinds issued by the front and evaluated by the back
    typedef logic [3:0] pt_code_t;
    localparam pt_code_t PT_ZERO = 4'd0;
    localparam pt_code_t PT_W0   = 4'd1;
    localparam pt_code_t PT_W1   = 4'd2;
    localparam pt_code_t PT_W2   = 4'd3;
    localparam pt_code_t PT_V    = 4'd4;
    localparam pt_code_t PT_LIN_A = 4'd5;
    localparam pt_code_t PT_LIN_B = 4'd6;
    localparam pt_code_t PT_BS_S  = 4'd7;
    localparam pt_code_t PT_BS_A  = 4'd8;
    localparam pt_code_t PT_BS_B  = 4'd9;
    localparam pt_code_t PT_BS_C  = 4'd10;
    localparam pt_code_t PT_CR_A  = 4'd11;
    localparam pt_code_t PT_CR_B  = 4'd12;

    typedef logic [LANES-1:0][LANE_W-1:0] vec_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] width_in;
        logic               curve_end;
    } vtx_in_t;

    typedef struct packed {
        logic signed [31:0] bez_x;
        logic signed [31:0] bez_y;
        logic signed [31:0] bez_z;
        logic signed [31:0] bez_width;
        logic               last_of_curve;
        logic               rejected;
    } bez_out_t;

    // One classified vertex: its data and the points it releases
    typedef struct packed {
        vec_t                vtx;
        logic [2:0]          npts;
        pt_code_t [3:0]      codes;
        logic                last;
        logic                rej;
    } job_t;

endpackage

`default_nettype wire

>>> sv/cbb_front.sv
`default_nettype none

module cbb_front #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire cbb_pkg::vtx_in_t s_data,
    input  wire logic [1:0]       basis_mode,
    input  wire logic             q_full,
    output logic                  q_push,
    output cbb_pkg::job_t         q_job
);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [COUNT_BITS-1:0] bez_cnt;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classify the beat: which Bezier points it releases, and the next count
    always_comb begin
        count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;
        bez_cnt   = (count_reg > COUNT_BITS'(6)) ? COUNT_BITS'(4) : count_reg;
        count_next = count_inc;

        q_job.vtx[0] = s_data.pos_x;
        q_job.vtx[1] = s_data.pos_y;
        q_job.vtx[2] = s_data.pos_z;
        q_job.vtx[3] = s_data.width_in;
        q_job.npts   = 3'd0;
        q_job.codes  = {4{cbb_pkg::PT_ZERO}};
        q_job.last   = s_data.curve_end;
        q_job.rej    = 1'b0;

        unique case (basis_mode)
            cbb_pkg::MODE_LINEAR: begin
                if (count_reg == COUNT_BITS'(1)) begin
                    q_job.codes[0] = cbb_pkg::PT_W2;
                    q_job.codes[1] = cbb_pkg::PT_LIN_A;
                    q_job.codes[2] = cbb_pkg::PT_LIN_B;
                    q_job.codes[3] = cbb_pkg::PT_V;
                    q_job.npts     = 3'd4;
                end else if (count_reg != '0) begin
                    q_job.codes[0] = cbb_pkg::PT_LIN_A;
                    q_job.codes[1] = cbb_pkg::PT_LIN_B;
                    q_job.codes[2] = cbb_pkg::PT_V;
                    q_job.npts     = 3'd3;
                end
            end
            cbb_pkg::MODE_BEZIER: begin
                if (bez_cnt == COUNT_BITS'(3)) begin
                    q_job.codes[0] = cbb_pkg::PT_W0;
                    q_job.codes[1] = cbb_pkg::PT_W1;
                    q_job.codes[2] = cbb_pkg::PT_W2;
                    q_job.codes[3] = cbb_pkg::PT_V;
                    q_job.npts     = 3'd4;
                    count_next     = COUNT_BITS'(4);
                end else if (bez_cnt == COUNT_BITS'(6)) begin
                    q_job.codes[0] = cbb_pkg::PT_W1;
                    q_job.codes[1] = cbb_pkg::PT_W2;
                    q_job.codes[2] = cbb_pkg::PT_V;
                    q_job.npts     = 3'd3;
                    count_next     = COUNT_BITS'(4);
                end else begin
                    count_next = bez_cnt + 1'b1;
                end
            end
            cbb_pkg::MODE_BSPLINE: begin
                if (count_reg == COUNT_BITS'(3)) begin
                    q_job.codes[0] = cbb_pkg::PT_BS_S;
                    q_job.codes[1] = cbb_pkg::PT_BS_A;
                    q_job.codes[2] = cbb_pkg::PT_BS_B;
                    q_job.codes[3] = cbb_pkg::PT_BS_C;
                    q_job.npts     = 3'd4;
                end else if (count_reg > COUNT_BITS'(3)) begin
                    q_job.codes[0] = cbb_pkg::PT_BS_A;
                    q_job.codes[1] = cbb_pkg::PT_BS_B;
                    q_job.codes[2] = cbb_pkg::PT_BS_C;
                    q_job.npts     = 3'd3;
                end
            end
            cbb_pkg::MODE_CATMULL: begin
                if (count_reg == COUNT_BITS'(3)) begin
                    q_job.codes[0] = cbb_pkg::PT_W1;
                    q_job.codes[1] = cbb_pkg::PT_CR_A;
                    q_job.codes[2] = cbb_pkg::PT_CR_B;
                    q_job.codes[3] = cbb_pkg::PT_W2;
                    q_job.npts     = 3'd4;
                end else if (count_reg > COUNT_BITS'(3)) begin
                    q_job.codes[0] = cbb_pkg::PT_CR_A;
                    q_job.codes[1] = cbb_pkg::PT_CR_B;
                    q_job.codes[2] = cbb_pkg::PT_W2;
                    q_job.npts     = 3'd3;
                end
            end
            default: begin
                q_job.npts = 3'd0;
            end
        endcase

        // Close the curve; an end without a segment becomes a reject point
        if (s_data.curve_end) begin
            if (q_job.npts == 3'd0) begin
                q_job.codes[0] = cbb_pkg::PT_ZERO;
                q_job.npts     = 3'd1;
                q_job.rej      = 1'b1;
            end
            count_next = '0;
        end
    end

    // Update the vertex count on every accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (q_push) begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/cbb_queue.sv
`default_nettype none

module cbb_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_push,
    input  wire cbb_pkg::job_t q_job,
    output logic               q_full,
    input  wire logic          q_pop,
    output logic               q_valid,
    output cbb_pkg::job_t      q_head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    cbb_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;

    assign q_full  = (cnt_reg == (PTR_W + 1)'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_head  = mem_reg[rd_ptr_reg];

    // Store pushed beats
    always_ff @(posedge aclk) begin
        if (q_push) begin
            mem_reg[wr_ptr_reg] <= q_job;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (q_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (q_push && !q_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (q_pop && !q_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/cbb_back.sv
`default_nettype none

module cbb_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  wire cbb_pkg::job_t q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output cbb_pkg::bez_out_t  m_data
);

    localparam int L = cbb_pkg::LANES;
    localparam int W = cbb_pkg::ACC_W;
    localparam int DIV_STAGES = 3;
    localparam int NIBS_PER_STAGE = W / 4 / DIV_STAGES;

    typedef struct packed {
        logic signed [3:0] w0;
        logic signed [3:0] w1;
        logic signed [3:0] w2;
        logic signed [3:0] w3;
        logic              div6;
    } wts_t;

    typedef struct packed {
        logic [W-1:0] val;
        logic [1:0]   rem;
    } div_state_t;

    // Weights of the window (oldest first) and the new vertex per point kind
    function automatic wts_t pt_weights(input cbb_pkg::pt_code_t code);
        wts_t r;
        r = '0;
        unique case (code)
            cbb_pkg::PT_ZERO:  r = '0;
            cbb_pkg::PT_W0:    r = '{4'sd3, 4'sd0, 4'sd0, 4'sd0, 1'b0};
            cbb_pkg::PT_W1:    r = '{4'sd0, 4'sd3, 4'sd0, 4'sd0, 1'b0};
            cbb_pkg::PT_W2:    r = '{4'sd0, 4'sd0, 4'sd3, 4'sd0, 1'b0};
            cbb_pkg::PT_V:     r = '{4'sd0, 4'sd0, 4'sd0, 4'sd3, 1'b0};
            cbb_pkg::PT_LIN_A: r = '{4'sd0, 4'sd0, 4'sd2, 4'sd1, 1'b0};
            cbb_pkg::PT_LIN_B: r = '{4'sd0, 4'sd0, 4'sd1, 4'sd2, 1'b0};
            cbb_pkg::PT_BS_S:  r = '{4'sd1, 4'sd4, 4'sd1, 4'sd0, 1'b1};
            cbb_pkg::PT_BS_A:  r = '{4'sd0, 4'sd2, 4'sd1, 4'sd0, 1'b0};
            cbb_pkg::PT_BS_B:  r = '{4'sd0, 4'sd1, 4'sd2, 4'sd0, 1'b0};
            cbb_pkg::PT_BS_C:  r = '{4'sd0, 4'sd1, 4'sd4, 4'sd1, 1'b1};
            cbb_pkg::PT_CR_A:  r = '{-4'sd1, 4'sd6, 4'sd1, 4'sd0, 1'b1};
            cbb_pkg::PT_CR_B:  r = '{4'sd0, 4'sd1, 4'sd6, -4'sd1, 1'b1};
            default:           r = '0;
        endcase
        return r;
    endfunction

    // Multiply a lane by a small weight with shifts and adds
    function automatic logic signed [W-1:0] scale(input logic signed [31:0] x,
                                                  input logic signed [3:0] w);
        logic signed [W-1:0] xe;
        logic signed [W-1:0] r;
        xe = W'(x);
        case (w)
            4'sd1:   r = xe;
            4'sd2:   r = xe <<< 1;
            4'sd3:   r = (xe <<< 1) + xe;
            4'sd4:   r = xe <<< 2;
            4'sd6:   r = (xe <<< 2) + (xe <<< 1);
            -4'sd1:  r = -xe;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Long division by 3, NIBS_PER_STAGE (three) nibbles from nibble hi downward
    function automatic div_state_t div3_run(input div_state_t s, input int hi);
        div_state_t  r;
        logic [5:0]  nxt;
        logic [11:0] prod;
        logic [3:0]  qd;
        logic [5:0]  back;
        r = s;
        for (int k = 0; k < NIBS_PER_STAGE; k++) begin
            nxt  = {r.rem, r.val[(hi - k) * 4 +: 4]};
            prod = 12'(nxt) * 12'd43;
            qd   = prod[10:7];
            back = {1'b0, qd, 1'b0} + {2'b00, qd};
            r.val[(hi - k) * 4 +: 4] = qd;
            r.rem = 2'(nxt - back);
        end
        return r;
    endfunction

    cbb_pkg::vec_t win_reg [3];
    logic [1:0]    idx_reg;

    logic          adv;
    logic          issue;
    logic          job_done;
    wts_t          wts;

    logic                a_vld_reg;
    logic signed [W-1:0] a_term_reg [L][4];
    logic                a_div6_reg;
    logic                a_last_reg;
    logic                a_rej_reg;

    logic                b_vld_reg;
    logic signed [W-1:0] b_sum_reg [L];
    logic                b_div6_reg;
    logic                b_last_reg;
    logic                b_rej_reg;

    logic                c_vld_reg;
    logic [W-1:0]        c_mag_reg [L];
    logic                c_neg_reg [L];
    logic                c_last_reg;
    logic                c_rej_reg;

    logic                d_vld_reg  [DIV_STAGES];
    div_state_t          d_st_reg   [DIV_STAGES][L];
    logic                d_neg_reg  [DIV_STAGES][L];
    logic                d_last_reg [DIV_STAGES];
    logic                d_rej_reg  [DIV_STAGES];

    logic                m_valid_reg;
    cbb_pkg::bez_out_t   m_data_reg;
    logic [31:0]         res [L];

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Whole pipeline moves when the output register is free or drains
    assign adv      = !m_valid_reg || m_ready;
    assign job_done = (q_head.npts == 3'd0) || ({1'b0, idx_reg} == q_head.npts - 3'd1);
    assign issue    = q_valid && adv && (q_head.npts != 3'd0);
    assign q_pop    = q_valid && adv && job_done;
    assign wts      = pt_weights(q_head.codes[idx_reg]);

    // Step through the points of the head beat; shift the window when it leaves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (issue) begin
                idx_reg <= job_done ? 2'd0 : idx_reg + 1'b1;
            end
            if (q_pop) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= q_head.vtx;
            end
        end
    end

    // Valid bits of the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int s = 0; s < DIV_STAGES; s++) begin
                d_vld_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            a_vld_reg <= issue;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg[0] <= c_vld_reg;
            for (int s = 1; s < DIV_STAGES; s++) begin
                d_vld_reg[s] <= d_vld_reg[s-1];
            end
            m_valid_reg <= d_vld_reg[DIV_STAGES-1];
        end
    end

    // Saturate the signed quotient to 32 bits
    always_comb begin
        for (int l = 0; l < L; l++) begin
            if (!d_neg_reg[DIV_STAGES-1][l]) begin
                res[l] = (d_st_reg[DIV_STAGES-1][l].val > W'(32'h7FFF_FFFF)) ?
                         32'h7FFF_FFFF : d_st_reg[DIV_STAGES-1][l].val[31:0];
            end else begin
                res[l] = (d_st_reg[DIV_STAGES-1][l].val > W'(32'h8000_0000)) ?
                         32'h8000_0000 : ~d_st_reg[DIV_STAGES-1][l].val[31:0] + 1'b1;
            end
        end
    end

    // Datapath: scale, sum, magnitude and rounding bias, divide, saturate
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < L; l++) begin
                a_term_reg[l][0] <= scale(win_reg[0][l], wts.w0);
                a_term_reg[l][1] <= scale(win_reg[1][l], wts.w1);
                a_term_reg[l][2] <= scale(win_reg[2][l], wts.w2);
                a_term_reg[l][3] <= scale(q_head.vtx[l], wts.w3);
            end
            a_div6_reg <= wts.div6;
            a_last_reg <= q_head.last && job_done;
            a_rej_reg  <= q_head.rej;

            for (int l = 0; l < L; l++) begin
                b_sum_reg[l] <= (a_term_reg[l][0] + a_term_reg[l][1])
                              + (a_term_reg[l][2] + a_term_reg[l][3]);
            end
            b_div6_reg <= a_div6_reg;
            b_last_reg <= a_last_reg;
            b_rej_reg  <= a_rej_reg;

            for (int l = 0; l < L; l++) begin
                c_neg_reg[l] <= b_sum_reg[l][W-1];
                if (b_div6_reg) begin
                    c_mag_reg[l] <= ((b_sum_reg[l][W-1] ? W'(-b_sum_reg[l])
                                                        : W'(b_sum_reg[l])) + W'(3)) >> 1;
                end else begin
                    c_mag_reg[l] <= (b_sum_reg[l][W-1] ? W'(-b_sum_reg[l])
                                                       : W'(b_sum_reg[l])) + W'(1);
                end
            end
            c_last_reg <= b_last_reg;
            c_rej_reg  <= b_rej_reg;

            for (int l = 0; l < L; l++) begin
                d_st_reg[0][l]  <= div3_run('{c_mag_reg[l], 2'b00}, W / 4 - 1);
                d_neg_reg[0][l] <= c_neg_reg[l];
            end
            d_last_reg[0] <= c_last_reg;
            d_rej_reg[0]  <= c_rej_reg;
            for (int s = 1; s < DIV_STAGES; s++) begin
                for (int l = 0; l < L; l++) begin
                    d_st_reg[s][l]  <= div3_run(d_st_reg[s-1][l],
                                                W / 4 - 1 - s * NIBS_PER_STAGE);
                    d_neg_reg[s][l] <= d_neg_reg[s-1][l];
                end
                d_last_reg[s] <= d_last_reg[s-1];
                d_rej_reg[s]  <= d_rej_reg[s-1];
            end

            m_data_reg.bez_x         <= res[0];
            m_data_reg.bez_y         <= res[1];
            m_data_reg.bez_z         <= res[2];
            m_data_reg.bez_width     <= res[3];
            m_data_reg.last_of_curve <= d_last_reg[DIV_STAGES-1];
            m_data_reg.rejected      <= d_rej_reg[DIV_STAGES-1];
        end
    end

endmodule

`default_nettype wire

>>> sv/curve_basis_to_bezier.sv
// Converts the control vertices of a curve into endpoint-sharing cubic
// Bezier points. Vertices (Q16.16 x, y, z, width, plus a curve_end flag)
// arrive one per beat on the s_ channel; Bezier points leave one per beat
// on the m_ channel, last_of_curve marking the final point of a curve and
// rejected marking the single zero point of a curve that was too short.
// basis_mode (APB, offset 0) picks linear, Bezier, B-spline or Catmull-Rom;
// write it only while the block is idle.
// The front classifies each vertex and updates the vertex count, then
// hands it to a two-entry queue. The back evaluates one point per cycle
// while its output is not stalled, in a seven-stage pipeline (scale, sum,
// round bias, three divide-by-3 stages, saturate). It issues the points of
// a vertex in turn and pops the vertex with its last one, so it takes no
// new vertex before it is through with the last. Outside Bezier mode a
// vertex releases 3 points, 4 on the first segment, none before it.
// Reset clears the count, the vertex window, the mode and all valid bits.
// When m_valid is high and m_ready low the whole back pipeline holds, the
// queue fills, and s_ready drops once both queue entries are taken.
`default_nettype none

module curve_basis_to_bezier #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cbb_pkg::vtx_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cbb_pkg::bez_out_t      m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [1:0]    mode_reg;
    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    cbb_pkg::job_t q_job;
    cbb_pkg::job_t q_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == cbb_pkg::REG_BASIS_MODE) ? {30'd0, mode_reg} : 32'd0;

    // Register write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= cbb_pkg::MODE_LINEAR;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == cbb_pkg::REG_BASIS_MODE) begin
            mode_reg <= pwdata[1:0];
        end
    end

    cbb_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .basis_mode (mode_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (q_job)
    );

    cbb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_job   (q_job),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    cbb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
